FILE: src/ste_pkg.sv
// ----------------------------------------------------------------------------
// ste_pkg
// Types, codes and sizes shared by the sorted table equal-count block.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W     = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ORDER = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_CHK,
        S_SEARCH,
        S_SRCH_CMP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic app_read;
        logic app_check;
        logic srch_read;
        logic srch_cmp;
        logic phase_next;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic search_busy;
        logic upper_phase;
    } dp_stat_t;

endpackage

FILE: src/ste_if.sv
// ----------------------------------------------------------------------------
// ste_req_if / ste_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface ste_req_if;
    import ste_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface ste_rsp_if;
    import ste_pkg::*;

    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  match_count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output match_count, output status, input ready);
    modport sink   (input valid, input match_count, input status, output ready);
endinterface

FILE: src/ste_ctrl.sv
// ----------------------------------------------------------------------------
// ste_ctrl
// Sequencer: decodes each request beat and steps the datapath through append
// checks and the two bisection passes, then hands the result to the output.
// ----------------------------------------------------------------------------
module ste_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic [ste_pkg::OP_W-1:0] req_operation,
    output logic                     req_ready,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output ste_pkg::ctrl_cmd_t       cmd,
    input  ste_pkg::dp_stat_t        stat
);
    import ste_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   req_fire;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign slot_free = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_operation)
                        OP_APPEND: state_next = stat.full ? S_RESULT : S_APP_RD;
                        OP_QUERY:  state_next = S_SEARCH;
                        default:   state_next = S_RESULT;
                    endcase
                end
            end
            S_APP_RD:   state_next = S_APP_CHK;
            S_APP_CHK:  state_next = S_RESULT;
            S_SEARCH:
            begin
                if (stat.search_busy)
                    state_next = S_SRCH_CMP;
                else if (!stat.upper_phase)
                    state_next = S_RESULT;
            end
            S_SRCH_CMP: state_next = S_SEARCH;
            S_RESULT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load  = req_fire;
                cmd.clear = req_fire && (req_operation == OP_CLEAR);
            end
            S_APP_RD:   cmd.app_read  = 1'b1;
            S_APP_CHK:  cmd.app_check = 1'b1;
            S_SEARCH:
            begin
                cmd.srch_read  = stat.search_busy;
                cmd.phase_next = !stat.search_busy && stat.upper_phase;
            end
            S_SRCH_CMP: cmd.srch_cmp = 1'b1;
            S_RESULT:   cmd.emit     = slot_free;
            default:    cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_query_enters_search: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req_operation == OP_QUERY) |=> state_reg == S_SEARCH)
        else $error("query did not start search");

    a_rsp_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESULT)
        else $error("response raised outside result state");

    a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_IDLE)
        else $error("emit did not return to idle");

endmodule

FILE: src/ste_dp.sv
// ----------------------------------------------------------------------------
// ste_dp
// Datapath: entry memory, fill count, bisection bounds, append order check
// and the output payload registers.
// ----------------------------------------------------------------------------
module ste_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ste_pkg::ctrl_cmd_t              cmd,
    output ste_pkg::dp_stat_t               stat,
    input  logic [ste_pkg::OP_W-1:0]        req_operation,
    input  logic signed [ste_pkg::VALUE_W-1:0] req_value,
    output logic [ste_pkg::COUNT_W-1:0]     rsp_match_count,
    output logic [ste_pkg::STATUS_W-1:0]    rsp_status
);
    import ste_pkg::*;

    logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [OP_W-1:0]           op_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic [COUNT_W-1:0]        lo_reg;
    logic [COUNT_W-1:0]        hi_reg;
    logic [COUNT_W-1:0]        mid_reg;
    logic [COUNT_W-1:0]        up_reg;
    logic                      upper_reg;
    status_t                   status_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [COUNT_W-1:0]        match_out_reg;
    logic [STATUS_W-1:0]       status_out_reg;

    logic [COUNT_W:0]          mid_sum;
    logic [COUNT_W-1:0]        mid;
    logic [COUNT_W-1:0]        last_idx;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      order_bad;
    logic                      wr_en;
    logic                      go_right;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[COUNT_W:1];
    assign last_idx  = count_reg - COUNT_W'(1);
    assign rd_addr   = cmd.app_read ? last_idx[ADDR_W-1:0] : mid[ADDR_W-1:0];
    assign order_bad = (count_reg != '0) && (key_reg < rd_data_reg);
    assign wr_en     = cmd.app_check && !order_bad;
    assign go_right  = upper_reg ? (rd_data_reg <= key_reg) : (rd_data_reg < key_reg);

    assign stat.full        = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign stat.search_busy = (lo_reg < hi_reg);
    assign stat.upper_phase = upper_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (wr_en)
            count_next = count_reg + COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[ADDR_W-1:0]] <= key_reg;
        if (cmd.app_read || cmd.srch_read)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= req_operation;
            key_reg    <= req_value;
            lo_reg     <= '0;
            hi_reg     <= count_reg;
            upper_reg  <= 1'b1;
            status_reg <= ((req_operation == OP_APPEND) && stat.full) ? ST_FULL : ST_OK;
        end
        else
        begin
            if (cmd.app_check && order_bad)
                status_reg <= ST_ORDER;
            if (cmd.srch_read)
                mid_reg <= mid;
            if (cmd.srch_cmp)
            begin
                if (go_right)
                    lo_reg <= mid_reg + COUNT_W'(1);
                else
                    hi_reg <= mid_reg;
            end
            if (cmd.phase_next)
            begin
                up_reg    <= lo_reg;
                lo_reg    <= '0;
                hi_reg    <= count_reg;
                upper_reg <= 1'b0;
            end
        end
        if (cmd.emit)
        begin
            match_out_reg  <= (op_reg == OP_QUERY) ? (up_reg - lo_reg) : '0;
            status_out_reg <= status_reg;
        end
    end

    assign rsp_match_count = match_out_reg;
    assign rsp_status      = status_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("accepted append did not grow the table");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_cmp |-> (lo_reg <= mid_reg) && (mid_reg < hi_reg))
        else $error("bisection midpoint outside bounds");

endmodule

FILE: src/sorted_table_equal_count.sv
// A clear or unused op, or an append to a full table, goes straight to the result state;
// an append reads the last entry and checks order; a query runs an upper then a lower bisection.
// One item at a time: each bisection step is a memory read plus a compare.
// A finished response waits in an output register while the next beat is taken.
// Reset: asynchronous active low; empties the table (count to zero), memory not cleared.
// ----------------------------------------------------------------------------
// sorted_table_equal_count
// Sorted table of signed entries: clear, ordered append, count of equal entries.
// ----------------------------------------------------------------------------
module sorted_table_equal_count
(
    input logic    clk,
    input logic    rst_n,
    ste_req_if.sink   req,
    ste_rsp_if.source rsp
);
    import ste_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ste_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_ready     (req.ready),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .cmd           (cmd),
        .stat          (stat)
    );

    ste_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_operation   (req.operation),
        .req_value       (req.value),
        .rsp_match_count (rsp.match_count),
        .rsp_status      (rsp.status)
    );

endmodule
